// File: hw/rtl/abs_pkg.sv
// Package: shared types and constants for the alternating-bit sender.
package abs_pkg;

    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_ACK      = 2'd1;
    localparam logic [1:0] KIND_EXPIRY   = 2'd2;
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    localparam int SUM_MOD = 255;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] ack_number;
    } in_item_t;

    typedef struct packed {
        logic        seq_bit;
        logic [14:0] checksum;
        logic [7:0]  payload_byte;
        logic [5:0]  byte_index;
        logic        last;
        logic        timer_start;
        logic        timer_stop;
        logic        no_packet;
        logic        dropped;
    } out_item_t;

    // 14-bit value mod 255: fold then one correction.
    function automatic logic [7:0] mod255(input logic [13:0] v);
        logic [8:0] f;
        f = {1'b0, v[7:0]} + {3'b000, v[13:8]};
        if (f >= 9'(SUM_MOD)) f = f - 9'(SUM_MOD);
        mod255 = f[7:0];
    endfunction

endpackage

// File: hw/rtl/abs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module abs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// File: hw/rtl/alternating_bit_sender_unit.sv
// Top level: alternating-bit sender with packet FIFO held in RAM.
// A plain byte or an ignored transaction is taken without leaving ST_IDLE; a notice result or the
// first byte of a send is registered from the state entered at acceptance (the RAM read issues at acceptance).
// One transaction at a time: s_ready is low outside ST_IDLE and while the output is stalled,
// so a send holds off the next acceptance until its last byte is loaded to the output.
// Reset: aresetn synchronous active low clears pointers, sums and protocol bits.
module alternating_bit_sender_unit #(
    parameter int PAYLOAD_BYTES = 20,
    parameter int QUEUE_DEPTH   = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  abs_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output abs_pkg::out_item_t m_data,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata
);
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int PW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int MD = QUEUE_DEPTH * PAYLOAD_BYTES;
    localparam int MW = (MD > 1) ? $clog2(MD) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SEND = 2'd1;
    localparam logic [1:0] ST_NOTE = 2'd2;

    logic [15:0]   timer_period_reg;
    logic [1:0]    state_reg;
    logic [QW-1:0] head_reg, tail_reg;
    logic [CW-1:0] count_reg;
    logic          next_seq_reg, exp_ack_reg, awaiting_reg;
    logic [PW-1:0] fill_reg;
    logic [13:0]   bsum_reg, rsum_reg;
    logic [PW-1:0] rd_idx_reg;
    logic          stop_first_reg;
    logic          note_stop_reg, note_drop_reg;
    logic [MW-1:0] head_base_reg;
    logic          hdr_fwd_reg;
    logic [15:0]   fwd_hdr_reg;
    logic [7:0]    fwd_byte_reg;

    // Payload and header RAM port signals.
    logic          pay_we;
    logic [MW-1:0] pay_waddr, pay_raddr;
    logic [7:0]    pay_rdata;
    logic          hdr_we;
    logic [QW-1:0] hdr_raddr;
    logic [15:0]   hdr_rdata;

    logic          acc, full, pkt_done, ack_match, out_free;
    logic [13:0]   bsum_next, rsum_next;
    logic [14:0]   new_sum;
    logic [QW-1:0] head_inc, tail_inc;
    logic [MW-1:0] tail_base, inc_base;

    // read stream: rd_idx is the byte being requested; result appears next cycle
    logic          adv, out_load;
    logic [PW-1:0] out_idx_reg;
    logic          out_pend_reg;
    logic [15:0]   hdr_word;
    logic [7:0]    pay_byte;

    abs_ram #(.WIDTH(8), .DEPTH(MD)) u_pay (
        .aclk(aclk), .we(pay_we), .waddr(pay_waddr), .wdata(s_data.data_byte),
        .raddr(pay_raddr), .rdata(pay_rdata)
    );
    abs_ram #(.WIDTH(16), .DEPTH(QUEUE_DEPTH)) u_hdr (
        .aclk(aclk), .we(hdr_we), .waddr(tail_reg),
        .wdata({next_seq_reg, new_sum}), .raddr(hdr_raddr), .rdata(hdr_rdata)
    );

    assign out_free  = !m_valid || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign acc       = s_valid && s_ready;
    assign full      = count_reg >= CW'(QUEUE_DEPTH);
    assign pkt_done  = fill_reg == PW'(PAYLOAD_BYTES - 1);
    assign ack_match = s_data.ack_number == {15'd0, exp_ack_reg};
    assign bsum_next = bsum_reg + 14'(abs_pkg::mod255({6'd0, s_data.data_byte}));
    assign rsum_next = rsum_reg + 14'(abs_pkg::mod255(bsum_next));
    assign new_sum   = 15'(bsum_next) + 15'(rsum_next);
    assign head_inc  = (head_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc  = (tail_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign tail_base = MW'(tail_reg * PAYLOAD_BYTES);
    assign inc_base  = MW'(head_inc * PAYLOAD_BYTES);

    assign pay_we    = acc && s_data.kind == abs_pkg::KIND_DATA && !full;
    assign pay_waddr = tail_base + MW'(fill_reg);
    assign hdr_we    = pay_we && pkt_done;

    assign adv      = state_reg == ST_SEND && out_free;
    assign out_load = (state_reg == ST_NOTE && out_free) || (adv && out_pend_reg);
    // header (and a one-byte payload) written at the send's acceptance edge
    assign hdr_word = hdr_fwd_reg ? fwd_hdr_reg : hdr_rdata;
    assign pay_byte = (hdr_fwd_reg && PAYLOAD_BYTES == 1) ? fwd_byte_reg : pay_rdata;

    // Start a send and choose which head.
    logic          start_send, use_inc, start_stop;
    always_comb begin
        start_send = 1'b0;
        use_inc    = 1'b0;
        start_stop = 1'b0;
        if (acc) begin
            unique case (s_data.kind)
                abs_pkg::KIND_DATA:
                    start_send = pkt_done && !full && !awaiting_reg;
                abs_pkg::KIND_ACK: begin
                    if (ack_match) begin
                        use_inc    = count_reg != '0;
                        start_send = count_reg > CW'(1);
                        start_stop = 1'b1;
                    end else begin
                        start_send = count_reg != '0;
                    end
                end
                abs_pkg::KIND_EXPIRY: start_send = count_reg != '0;
                default: ;
            endcase
        end
    end

    always_comb begin
        hdr_raddr = use_inc ? head_inc : head_reg;
        if (state_reg == ST_SEND)
            pay_raddr = head_base_reg + MW'((adv && out_pend_reg) ? rd_idx_reg : out_idx_reg);
        else
            pay_raddr = (use_inc ? inc_base : MW'(head_reg * PAYLOAD_BYTES));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_period_reg <= 16'd1000;
            state_reg        <= ST_IDLE;
            head_reg <= '0; tail_reg <= '0; count_reg <= '0;
            next_seq_reg <= 1'b0; exp_ack_reg <= 1'b0; awaiting_reg <= 1'b0;
            fill_reg <= '0; bsum_reg <= '0; rsum_reg <= '0;
            m_valid <= 1'b0; out_pend_reg <= 1'b0; hdr_fwd_reg <= 1'b0;
        end else begin
            if (cfg_we) timer_period_reg <= cfg_wdata;
            if (m_valid && m_ready && !out_load) m_valid <= 1'b0;
            hdr_fwd_reg <= start_send && hdr_we;
            if (hdr_we) begin
                fwd_hdr_reg  <= {next_seq_reg, new_sum};
                fwd_byte_reg <= s_data.data_byte;
            end
            if (acc && s_data.kind == abs_pkg::KIND_DATA) begin
                if (pkt_done) begin
                    fill_reg <= '0; bsum_reg <= '0; rsum_reg <= '0;
                    if (full) begin
                        state_reg <= ST_NOTE; note_stop_reg <= 1'b0; note_drop_reg <= 1'b1;
                    end else begin
                        tail_reg     <= tail_inc;
                        count_reg    <= count_reg + 1'b1;
                        next_seq_reg <= ~next_seq_reg;
                        if (!awaiting_reg) awaiting_reg <= 1'b1;
                    end
                end else begin
                    fill_reg <= fill_reg + 1'b1;
                    bsum_reg <= bsum_next; rsum_reg <= rsum_next;
                end
            end
            if (acc && s_data.kind == abs_pkg::KIND_ACK && ack_match) begin
                exp_ack_reg <= ~exp_ack_reg;
                if (count_reg != '0) begin
                    head_reg  <= head_inc;
                    count_reg <= count_reg - 1'b1;
                end
                if (count_reg <= CW'(1)) begin
                    awaiting_reg <= 1'b0;
                    state_reg <= ST_NOTE; note_stop_reg <= 1'b1; note_drop_reg <= 1'b0;
                end
            end
            if (start_send) begin
                state_reg      <= ST_SEND;
                head_base_reg  <= use_inc ? inc_base : MW'(head_reg * PAYLOAD_BYTES);
                stop_first_reg <= start_stop;
                rd_idx_reg     <= (PAYLOAD_BYTES > 1) ? PW'(1) : '0;
                out_idx_reg    <= '0;
                out_pend_reg   <= 1'b1;
            end
            if (state_reg == ST_NOTE && out_free) begin
                m_valid <= 1'b1;
                m_data  <= '{seq_bit: 1'b0, checksum: '0, payload_byte: '0, byte_index: '0,
                             last: 1'b1, timer_start: 1'b0, timer_stop: note_stop_reg,
                             no_packet: 1'b1, dropped: note_drop_reg};
                state_reg <= ST_IDLE;
            end
            // pay_rdata holds byte out_idx when out_pend; hold via re-read when stalled
            if (adv && out_pend_reg) begin
                m_valid <= 1'b1;
                m_data  <= '{seq_bit: hdr_word[15], checksum: hdr_word[14:0],
                             payload_byte: pay_byte, byte_index: 6'(out_idx_reg),
                             last: out_idx_reg == PW'(PAYLOAD_BYTES - 1),
                             timer_start: out_idx_reg == PW'(PAYLOAD_BYTES - 1),
                             timer_stop: stop_first_reg && out_idx_reg == '0,
                             no_packet: 1'b0, dropped: 1'b0};
                stop_first_reg <= 1'b0;
                if (out_idx_reg == PW'(PAYLOAD_BYTES - 1)) begin
                    state_reg <= ST_IDLE;
                    out_pend_reg <= 1'b0;
                end else begin
                    out_idx_reg <= out_idx_reg + 1'b1;
                    rd_idx_reg  <= rd_idx_reg + 1'b1;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH)) else $error("count overflow");
    a_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == '0 && state_reg == ST_IDLE |-> !awaiting_reg || $past(acc))
        else $error("awaiting with empty queue");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_ready) else $error("ready while busy");
`endif
endmodule
